FILE: design/fgs_pkg.sv
// ----------------------------------------------------------------------------
// fgs_pkg
// Shared constants, codes and types of the gridding scatter block.
// ----------------------------------------------------------------------------
package fgs_pkg;

    localparam int GRID_SIZE   = 512;
    localparam int FREQ_POINTS = 1024;
    localparam int TABLE_LAST  = 512;
    localparam int SUPPORT_MAX = 8;

    localparam int GRID_W     = $clog2(GRID_SIZE);
    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int TAB_DEPTH  = TABLE_LAST + 1;
    localparam int TAB_W      = $clog2(TAB_DEPTH);
    localparam int ROW_W      = $clog2(SUPPORT_MAX);

    localparam int FS_W      = 24;
    localparam int HS_W      = 19;
    localparam int TS_W      = 26;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W     = 2;
    localparam int ANG_W     = 16;
    localparam int J_W       = 9;
    localparam int VAL_W     = 24;
    localparam int ADDR_W    = 18;
    localparam int CELL_DW   = 48;
    localparam int KW        = 18;
    localparam int RT_W      = FS_W + J_W;
    localparam int OP_W      = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [FS_W-1:0] FS_RESET = FS_W'(65536);
    localparam logic [HS_W-1:0] HS_RESET = HS_W'(163840);
    localparam logic [TS_W-1:0] TS_RESET = TS_W'(14024704);

    localparam logic [REQ_W-1:0] REQ_ACC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_KWR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TS = 2'd2;

    localparam logic [OP_W-1:0] OP_ACC = 2'd0;
    localparam logic [OP_W-1:0] OP_RD  = 2'd1;
    localparam logic [OP_W-1:0] OP_RDZ = 2'd2;
    localparam logic [OP_W-1:0] OP_KWR = 2'd3;

    typedef struct packed {
        logic [FS_W-1:0] freq_scale;
        logic [HS_W-1:0] half_support;
        logic [TS_W-1:0] table_spacing;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [RT_W-1:0]         rt;
        logic signed [ANG_W-1:0] cos_val;
        logic signed [ANG_W-1:0] sin_val;
        logic signed [VAL_W-1:0] pos_re;
        logic signed [VAL_W-1:0] pos_im;
        logic signed [VAL_W-1:0] neg_re;
        logic signed [VAL_W-1:0] neg_im;
        logic signed [VAL_W-1:0] fac_re;
        logic signed [VAL_W-1:0] fac_im;
        logic [ADDR_W-1:0]       address;
    } t_item;

endpackage

FILE: design/fgs_ram.sv
// ----------------------------------------------------------------------------
// fgs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/fgs_front.sv
// ----------------------------------------------------------------------------
// fgs_front
// Input side: accepts items, sorts them by kind and drops those with no effect.
// ----------------------------------------------------------------------------
module fgs_front import fgs_pkg::*; (
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic signed [ANG_W-1:0] i_cos_val,
    input  logic signed [ANG_W-1:0] i_sin_val,
    input  logic [J_W-1:0]          i_freq_index,
    input  logic signed [VAL_W-1:0] i_pos_re,
    input  logic signed [VAL_W-1:0] i_pos_im,
    input  logic signed [VAL_W-1:0] i_neg_re,
    input  logic signed [VAL_W-1:0] i_neg_im,
    input  logic signed [VAL_W-1:0] i_fac_re,
    input  logic signed [VAL_W-1:0] i_fac_im,
    input  logic [ADDR_W-1:0]       i_address,
    input  t_cfg                    i_cfg,
    input  logic                    i_full,
    input  logic                    i_clearing,
    output logic                    o_push,
    output t_item                   o_item
);

    logic            keep;
    logic [OP_W-1:0] op;

    assign o_stall = i_full | i_clearing;

    always_comb begin
        keep = 1'b0;
        op   = OP_ACC;
        case (i_req_type)
            REQ_ACC: begin
                keep = (i_freq_index != '0) && (int'(i_freq_index) < FREQ_POINTS / 2);
            end
            REQ_RD: begin
                keep = 1'b1;
                op   = (int'(i_address) < CELL_COUNT) ? OP_RD : OP_RDZ;
            end
            REQ_KWR: begin
                keep = int'(i_address) <= TABLE_LAST;
                op   = OP_KWR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_item.op      = op;
    assign o_item.rt      = RT_W'(i_cfg.freq_scale) * RT_W'(i_freq_index);
    assign o_item.cos_val = i_cos_val;
    assign o_item.sin_val = i_sin_val;
    assign o_item.pos_re  = i_pos_re;
    assign o_item.pos_im  = i_pos_im;
    assign o_item.neg_re  = i_neg_re;
    assign o_item.neg_im  = i_neg_im;
    assign o_item.fac_re  = i_fac_re;
    assign o_item.fac_im  = i_fac_im;
    assign o_item.address = i_address;

    assign o_push = i_valid & ~o_stall & keep;

endmodule

FILE: design/fgs_queue.sv
// ----------------------------------------------------------------------------
// fgs_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module fgs_queue import fgs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_item  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= nxt(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= nxt(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: design/fgs_back.sv
// ----------------------------------------------------------------------------
// fgs_back
// Execution side: grid clearing, sample scatter, cell read-out, table loads.
// ----------------------------------------------------------------------------
module fgs_back import fgs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_item                     i_item,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [CELL_DW-1:0] o_cell_re,
    output logic signed [CELL_DW-1:0] o_cell_im
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_CLR  = 5'd0;
    localparam logic [ST_W-1:0] S_IDLE = 5'd1;
    localparam logic [ST_W-1:0] S_CPX  = 5'd2;
    localparam logic [ST_W-1:0] S_POS  = 5'd3;
    localparam logic [ST_W-1:0] S_BOX  = 5'd4;
    localparam logic [ST_W-1:0] S_L0   = 5'd5;
    localparam logic [ST_W-1:0] S_L1   = 5'd6;
    localparam logic [ST_W-1:0] S_L2   = 5'd7;
    localparam logic [ST_W-1:0] S_L3   = 5'd8;
    localparam logic [ST_W-1:0] S_P0   = 5'd9;
    localparam logic [ST_W-1:0] S_P1   = 5'd10;
    localparam logic [ST_W-1:0] S_P2   = 5'd11;
    localparam logic [ST_W-1:0] S_P3   = 5'd12;
    localparam logic [ST_W-1:0] S_P4   = 5'd13;
    localparam logic [ST_W-1:0] S_RD0  = 5'd14;
    localparam logic [ST_W-1:0] S_RD1  = 5'd15;
    localparam logic [ST_W-1:0] S_RDZ  = 5'd16;

    localparam int PW   = 2 * VAL_W;
    localparam int SW   = PW + 1;
    localparam int AW   = SW - 22;
    localparam int CW   = RT_W + ANG_W + 3;
    localparam int LW   = CW + 1 - 31;
    localparam int DW   = HS_W + 15;
    // spare top bit keeps the rounding carry
    localparam int KPW  = DW + TS_W + 1;
    localparam int PIW  = KPW - 47;
    localparam int WW   = 2 * KW;
    localparam int QW   = WW + AW;
    localparam int INCW = QW - 32;
    localparam int GDW  = 2 * CELL_DW;

    localparam logic signed [CW-1:0]  MID31  = CW'(GRID_SIZE / 2) << 31;
    localparam logic signed [SW-1:0]  HALF22 = SW'(1) << 21;
    localparam logic signed [QW-1:0]  HALF32 = QW'(1) << 31;
    localparam logic [KPW-1:0]        HALF47 = KPW'(1) << 46;

    typedef struct packed {
        logic              ok;
        logic [GRID_W-1:0] lo;
        logic [GRID_W-1:0] hi;
    } t_span;

    function automatic t_span clamp_box(input logic signed [CW-1:0] c,
                                        input logic [HS_W-1:0] hs);
        logic signed [CW:0]   h31;
        logic signed [CW:0]   cx;
        logic signed [LW-1:0] lo_s;
        logic signed [LW-1:0] hi_s;
        t_span                sp;
        h31  = $signed({{(CW + 1 - HS_W - 15){1'b0}}, hs, 15'b0});
        cx   = $signed({c[CW-1], c});
        lo_s = -LW'((h31 - cx) >>> 31);
        hi_s = LW'((cx + h31) >>> 31);
        if (lo_s < LW'(1)) begin
            lo_s = LW'(1);
        end
        if (hi_s > LW'(GRID_SIZE - 1)) begin
            hi_s = LW'(GRID_SIZE - 1);
        end
        sp.ok = (lo_s <= hi_s);
        if (hi_s - lo_s >= LW'(SUPPORT_MAX)) begin
            hi_s = lo_s + LW'(SUPPORT_MAX - 1);
        end
        sp.lo = GRID_W'(lo_s);
        sp.hi = GRID_W'(hi_s);
        return sp;
    endfunction

    function automatic logic signed [INCW-1:0] rnd32(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] t;
        t = q + HALF32;
        return INCW'(t >>> 32);
    endfunction

    function automatic logic signed [CELL_DW-1:0] sat_add(
        input logic signed [CELL_DW-1:0] a,
        input logic signed [INCW-1:0]    b
    );
        logic signed [CELL_DW:0] s;
        s = a + b;
        if (s[CELL_DW] != s[CELL_DW-1]) begin
            return s[CELL_DW] ? {1'b1, {(CELL_DW - 1){1'b0}}}
                              : {1'b0, {(CELL_DW - 1){1'b1}}};
        end
        return s[CELL_DW-1:0];
    endfunction

    logic [ST_W-1:0]          r_state;
    logic [ST_W-1:0]          n_state;
    logic [CELL_W-1:0]        r_clr;
    logic                     r_out_valid;
    t_item                    r_it;
    logic [2:0]               r_c;
    logic signed [PW-1:0]     r_p1;
    logic signed [PW-1:0]     r_p2;
    logic signed [AW-1:0]     r_ar;
    logic signed [AW-1:0]     r_ai;
    logic signed [AW-1:0]     r_br;
    logic signed [AW-1:0]     r_bi;
    logic signed [CW-1:0]     r_u31;
    logic signed [CW-1:0]     r_v31;
    logic [GRID_W-1:0]        r_ul;
    logic [GRID_W-1:0]        r_uh;
    logic [GRID_W-1:0]        r_vl;
    logic [GRID_W-1:0]        r_vh;
    logic [GRID_W-1:0]        r_iu;
    logic [GRID_W-1:0]        r_iv;
    logic                     r_lrow;
    logic [DW-1:0]            r_d;
    logic [KPW-1:0]           r_kp;
    logic signed [KW-1:0]     r_rw;
    logic signed [KW-1:0]     r_row [SUPPORT_MAX];
    logic signed [WW-1:0]     r_w;
    logic signed [QW-1:0]     r_q_re;
    logic signed [QW-1:0]     r_q_im;
    logic signed [CELL_DW-1:0] r_out_re;
    logic signed [CELL_DW-1:0] r_out_im;

    logic                     g_we;
    logic [CELL_W-1:0]        g_waddr;
    logic [GDW-1:0]           g_wdata;
    logic                     g_re;
    logic [CELL_W-1:0]        g_raddr;
    logic [GDW-1:0]           g_rdata;
    logic                     t_we;
    logic [TAB_W-1:0]         t_waddr;
    logic [KW-1:0]            t_wdata;
    logic                     t_re;
    logic [TAB_W-1:0]         t_raddr;
    logic [KW-1:0]            t_rdata;

    logic                     out_free;
    logic                     out_load;
    logic [ROW_W-1:0]         ri;
    logic [CELL_W-1:0]        addr_a;
    logic [CELL_W-1:0]        addr_b;
    logic signed [CELL_DW-1:0] g_rd_re;
    logic signed [CELL_DW-1:0] g_rd_im;
    logic [GDW-1:0]           upd;
    t_span                    su;
    t_span                    sv;
    logic signed [VAL_W-1:0]  m1a;
    logic signed [VAL_W-1:0]  m1b;
    logic signed [VAL_W-1:0]  m2a;
    logic signed [VAL_W-1:0]  m2b;
    logic signed [SW-1:0]     csum;
    logic signed [AW-1:0]     cres;
    logic signed [CW:0]       ldiff;
    logic signed [CW:0]       lpos;
    logic signed [CW:0]       labs;
    logic [KPW-1:0]           kround;
    logic [PIW-1:0]           pidx;

    fgs_ram #(.WIDTH(GDW), .DEPTH(CELL_COUNT)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    fgs_ram #(.WIDTH(KW), .DEPTH(TAB_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign o_clearing = (r_state == S_CLR);
    assign o_valid    = r_out_valid;
    assign o_cell_re  = r_out_re;
    assign o_cell_im  = r_out_im;
    assign out_free   = ~r_out_valid | ~i_stall;
    assign o_pop      = (r_state == S_IDLE) & ~i_empty;

    assign ri      = ROW_W'(r_iv - r_vl);
    assign addr_a  = CELL_W'(r_iu) * CELL_W'(GRID_SIZE) + CELL_W'(r_iv);
    assign addr_b  = (CELL_W'(GRID_SIZE) - CELL_W'(r_iu)) * CELL_W'(GRID_SIZE)
                   + (CELL_W'(GRID_SIZE) - CELL_W'(r_iv));
    assign g_rd_re = g_rdata[GDW-1:CELL_DW];
    assign g_rd_im = g_rdata[CELL_DW-1:0];
    assign upd     = {sat_add(g_rd_re, rnd32(r_q_re)), sat_add(g_rd_im, rnd32(r_q_im))};
    assign su      = clamp_box(r_u31, i_cfg.half_support);
    assign sv      = clamp_box(r_v31, i_cfg.half_support);

    // complex product terms
    always_comb begin
        m1a = r_it.fac_re;
        m2a = r_it.fac_im;
        case (r_c)
            3'd1: begin
                m1b = r_it.pos_im;
                m2b = r_it.pos_re;
            end
            3'd2: begin
                m1b = r_it.neg_re;
                m2b = r_it.neg_im;
            end
            3'd3: begin
                m1b = r_it.neg_im;
                m2b = r_it.neg_re;
            end
            default: begin
                m1b = r_it.pos_re;
                m2b = r_it.pos_im;
            end
        endcase
        if (r_c == 3'd1 || r_c == 3'd4) begin
            csum = r_p1 - r_p2;
        end else begin
            csum = r_p1 + r_p2;
        end
        cres = AW'((csum + HALF22) >>> 22);
    end

    // kernel index
    always_comb begin
        lpos = '0;
        lpos[GRID_W+30:31] = r_lrow ? r_iv : r_iu;
        ldiff = (r_lrow ? $signed({r_v31[CW-1], r_v31}) : $signed({r_u31[CW-1], r_u31}))
              - lpos;
        labs  = (ldiff < 0) ? -ldiff : ldiff;
        kround = r_kp + HALF47;
        pidx   = kround[KPW-1:47];
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        g_we     = 1'b0;
        g_waddr  = addr_a;
        g_wdata  = upd;
        g_re     = 1'b0;
        g_raddr  = addr_a;
        t_we     = 1'b0;
        t_waddr  = i_item.address[TAB_W-1:0];
        t_wdata  = i_item.pos_re[KW-1:0];
        t_re     = 1'b0;
        t_raddr  = (int'(pidx) > TABLE_LAST) ? TAB_W'(TABLE_LAST) : TAB_W'(pidx);
        case (r_state)
            S_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_clr;
                g_wdata = '0;
                if (r_clr == CELL_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_item.op)
                        OP_ACC:  n_state = S_CPX;
                        OP_RD:   n_state = S_RD0;
                        OP_RDZ:  n_state = S_RDZ;
                        default: t_we    = 1'b1;
                    endcase
                end
            end
            S_CPX: begin
                if (r_c == 3'd4) begin
                    n_state = S_POS;
                end
            end
            S_POS: n_state = S_BOX;
            S_BOX: begin
                n_state = (su.ok && sv.ok) ? S_L0 : S_IDLE;
            end
            S_L0: n_state = S_L1;
            S_L1: n_state = S_L2;
            S_L2: begin
                t_re    = 1'b1;
                n_state = S_L3;
            end
            S_L3: n_state = r_lrow ? S_L0 : S_P0;
            S_P0: begin
                g_re    = 1'b1;
                n_state = S_P1;
            end
            S_P1: n_state = S_P2;
            S_P2: begin
                g_we    = 1'b1;
                n_state = S_P3;
            end
            S_P3: begin
                g_re    = 1'b1;
                g_raddr = addr_b;
                n_state = S_P4;
            end
            S_P4: begin
                g_we    = 1'b1;
                g_waddr = addr_b;
                if (r_iv != r_vh) begin
                    n_state = S_P0;
                end else if (r_iu != r_uh) begin
                    n_state = S_L0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD0: begin
                g_re    = 1'b1;
                g_raddr = r_it.address[CELL_W-1:0];
                n_state = S_RD1;
            end
            S_RD1: begin
                if (out_free) begin
                    out_load = 1'b1;
                    g_we     = 1'b1;
                    g_waddr  = r_it.address[CELL_W-1:0];
                    g_wdata  = '0;
                    n_state  = S_IDLE;
                end
            end
            S_RDZ: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_it <= i_item;
                end
                r_c <= '0;
            end
            S_CPX: begin
                r_p1 <= m1a * m1b;
                r_p2 <= m2a * m2b;
                r_c  <= r_c + 1'b1;
                case (r_c)
                    3'd1:    r_ar <= cres;
                    3'd2:    r_ai <= cres;
                    3'd3:    r_br <= cres;
                    3'd4:    r_bi <= cres;
                    default: ;
                endcase
            end
            S_POS: begin
                r_u31 <= $signed({1'b0, r_it.rt}) * $signed(r_it.cos_val) + MID31;
                r_v31 <= $signed({1'b0, r_it.rt}) * $signed(r_it.sin_val) + MID31;
            end
            S_BOX: begin
                r_ul   <= su.lo;
                r_uh   <= su.hi;
                r_vl   <= sv.lo;
                r_vh   <= sv.hi;
                r_iu   <= su.lo;
                r_iv   <= sv.lo;
                r_lrow <= 1'b1;
            end
            S_L0: r_d  <= labs[DW-1:0];
            S_L1: r_kp <= KPW'(r_d) * KPW'(i_cfg.table_spacing);
            S_L3: begin
                if (r_lrow) begin
                    r_row[ri] <= t_rdata;
                    if (r_iv == r_vh) begin
                        r_lrow <= 1'b0;
                    end else begin
                        r_iv <= r_iv + 1'b1;
                    end
                end else begin
                    r_rw <= t_rdata;
                    r_iv <= r_vl;
                end
            end
            S_P0: r_w <= r_rw * r_row[ri];
            S_P1: begin
                r_q_re <= r_w * r_ar;
                r_q_im <= r_w * r_ai;
            end
            S_P2: begin
                r_q_re <= r_w * r_br;
                r_q_im <= r_w * r_bi;
            end
            S_P4: begin
                if (r_iv != r_vh) begin
                    r_iv <= r_iv + 1'b1;
                end else if (r_iu != r_uh) begin
                    r_iu <= r_iu + 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            if (r_state == S_RD1) begin
                r_out_re <= g_rd_re;
                r_out_im <= g_rd_im;
            end else begin
                r_out_re <= '0;
                r_out_im <= '0;
            end
        end
    end

endmodule

FILE: design/fourier_gridding_scatter.sv
// ----------------------------------------------------------------------------
// fourier_gridding_scatter
// Convolution gridding of radial frequency samples onto a complex grid.
//
// After reset the grid is cleared one cell per cycle, all GRID_SIZE*GRID_SIZE
// cells (262144), with the input stalled; configuration writes are taken
// throughout. Items then pass a two-entry queue to a sequencer that owns a
// grid memory with one write and one read port. A kernel write is done as
// the item leaves the queue; a cell read reads the cell, then, once the
// output is free, hands it out and clears it. For an accumulate item each
// box cell costs two read-modify-writes of the grid memory, one for the cell
// and one for its mirror, and each kernel weight a table lookup. Samples with
// a zero or too high frequency index, kernel writes beyond the table and
// unused item kinds are dropped at the input and cost nothing in the sequencer.
// ----------------------------------------------------------------------------
module fourier_gridding_scatter import fgs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [REQ_W-1:0]          i_req_type,
    input  logic signed [ANG_W-1:0]   i_cos_val,
    input  logic signed [ANG_W-1:0]   i_sin_val,
    input  logic [J_W-1:0]            i_freq_index,
    input  logic signed [VAL_W-1:0]   i_pos_re,
    input  logic signed [VAL_W-1:0]   i_pos_im,
    input  logic signed [VAL_W-1:0]   i_neg_re,
    input  logic signed [VAL_W-1:0]   i_neg_im,
    input  logic signed [VAL_W-1:0]   i_fac_re,
    input  logic signed [VAL_W-1:0]   i_fac_im,
    input  logic [ADDR_W-1:0]         i_address,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [CELL_DW-1:0] o_cell_re,
    output logic signed [CELL_DW-1:0] o_cell_im,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    t_cfg  r_cfg;
    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    logic  clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_scale    <= FS_RESET;
            r_cfg.half_support  <= HS_RESET;
            r_cfg.table_spacing <= TS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FS:  r_cfg.freq_scale    <= i_cfg_data[FS_W-1:0];
                CFG_HS:  r_cfg.half_support  <= i_cfg_data[HS_W-1:0];
                CFG_TS:  r_cfg.table_spacing <= i_cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    fgs_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_cos_val    (i_cos_val),
        .i_sin_val    (i_sin_val),
        .i_freq_index (i_freq_index),
        .i_pos_re     (i_pos_re),
        .i_pos_im     (i_pos_im),
        .i_neg_re     (i_neg_re),
        .i_neg_im     (i_neg_im),
        .i_fac_re     (i_fac_re),
        .i_fac_im     (i_fac_im),
        .i_address    (i_address),
        .i_cfg        (r_cfg),
        .i_full       (full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_item       (push_item)
    );

    fgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (empty),
        .o_full  (full)
    );

    fgs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (head_item),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cell_re  (o_cell_re),
        .o_cell_im  (o_cell_im)
    );

endmodule

FILE: design/fgs_checker.sv
// ----------------------------------------------------------------------------
// fgs_checker
// Port-level checks of the gridding scatter block.
// ----------------------------------------------------------------------------
module fgs_checker import fgs_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [CELL_DW-1:0] o_cell_re,
    input logic signed [CELL_DW-1:0] o_cell_im
);

    // held result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_re) && $stable(o_cell_im))
        else $error("result item changed while stalled");

    // grid clear starts after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled during grid clear");

    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item present after reset");

    // right after reset is released there is no result and the input is stalled
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid && o_stall)
        else $error("result item during grid clear");

endmodule

bind fourier_gridding_scatter fgs_checker u_fgs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_cell_re (o_cell_re),
    .o_cell_im (o_cell_im)
);
